FILE: rtl/user_range_permission_check_defines.svh
// assertion macros for the range permission check rtl
`ifndef USER_RANGE_PERMISSION_CHECK_DEFINES_SVH
`define USER_RANGE_PERMISSION_CHECK_DEFINES_SVH

// expression must hold at every edge out of reset
`define URPC_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// antecedent implies consequent in the same cycle
`define URPC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define URPC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/urpc_pkg.sv
// shared types, codes and helpers for the range permission check
package urpc_pkg;

   localparam int DEF_PAGE_BITS   = 12;
   localparam int DEF_TABLE_PAGES = 1024;
   localparam int DEF_QUEUE_DEPTH = 2;

   localparam int ADDR_W      = 32;
   localparam int CSR_INDEX_W = 4;
   localparam int FLAG_W      = 4;

   localparam logic [ADDR_W-1:0] WIN_START_RESET = 32'd0;
   localparam logic [ADDR_W-1:0] WIN_END_RESET   = 32'd4194304;

   localparam logic [1:0] MODE_READ  = 2'd0;
   localparam logic [1:0] MODE_WRITE = 2'd1;
   localparam logic [1:0] MODE_ENTRY = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_WIN_START = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WIN_END   = 4'd1;

   localparam int FLAG_MAPPED   = 0;
   localparam int FLAG_PRESENT  = 1;
   localparam int FLAG_USER     = 2;
   localparam int FLAG_WRITABLE = 3;

   typedef enum logic [1:0] {
      KIND_ENTRY  = 2'd0,
      KIND_RESULT = 2'd1,
      KIND_WALK   = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type            kind;
      logic                need_write;
      logic                result;
      logic [FLAG_W-1:0]   flags;
   } cmd_type;

   function automatic logic page_ok(input logic [FLAG_W-1:0] flags, input logic need_write);
      page_ok = flags[FLAG_MAPPED] & flags[FLAG_PRESENT] & flags[FLAG_USER] &
                (~need_write | flags[FLAG_WRITABLE]);
   endfunction

endpackage

FILE: rtl/user_range_permission_check.sv
// top level of the user range permission check
// Checks whether a user access (start address, byte length) may proceed.
// Input channel: push/full with req_mode, req_address, req_length and the
// req_entry_* flags. A read or write check (mode 0 or 1) yields one result;
// a page entry write (mode 2) only fills the page flag store; mode 3 and
// entry writes to pages beyond the store are dropped without a result.
// Result channel: empty/pop with rsp_allowed, oldest result first.
// Window registers: csr_valid/csr_ready with csr_index and csr_data, index 0
// window start, 1 window end; csr_ready is always high.
// A transaction enters the command queue in the cycle it is accepted. A check
// decided by window and bounds tests loads the result register without a flag
// store read; a page walk reads the flag store once per touched page, in order,
// and stops at the first page that fails.
// After reset full stays high while the flag store is cleared, one entry a
// cycle; configuration writes are taken meanwhile.
// When the receiver stalls, the result register holds, the walker waits, the
// queue fills and full rises.
module user_range_permission_check #(
   parameter int PAGE_BITS   = urpc_pkg::DEF_PAGE_BITS,
   parameter int TABLE_PAGES = urpc_pkg::DEF_TABLE_PAGES,
   parameter int QUEUE_DEPTH = urpc_pkg::DEF_QUEUE_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [urpc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [urpc_pkg::ADDR_W-1:0]      csr_data,
   input  logic                             push,
   output logic                             full,
   input  logic [1:0]                       req_mode,
   input  logic [urpc_pkg::ADDR_W-1:0]      req_address,
   input  logic [urpc_pkg::ADDR_W-1:0]      req_length,
   input  logic                             req_entry_mapped,
   input  logic                             req_entry_present,
   input  logic                             req_entry_user,
   input  logic                             req_entry_writable,
   output logic                             empty,
   input  logic                             pop,
   output logic                             rsp_allowed
);
   import urpc_pkg::*;

   localparam int IDX_W   = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
   localparam int CMD_W   = $bits(cmd_type);
   localparam int ENTRY_W = CMD_W + 2 * IDX_W;

   cmd_type              push_cmd, pop_cmd;
   logic [IDX_W-1:0]     push_first, push_last, pop_first, pop_last;
   logic                 q_push, q_pop, q_full, q_empty, clearing;
   logic [ENTRY_W-1:0]   q_rd_data;

   urpc_front #(
      .PAGE_BITS   (PAGE_BITS),
      .TABLE_PAGES (TABLE_PAGES),
      .IDX_W       (IDX_W)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .push               (push),
      .full               (full),
      .req_mode           (req_mode),
      .req_address        (req_address),
      .req_length         (req_length),
      .req_entry_mapped   (req_entry_mapped),
      .req_entry_present  (req_entry_present),
      .req_entry_user     (req_entry_user),
      .req_entry_writable (req_entry_writable),
      .q_full             (q_full),
      .clearing           (clearing),
      .q_push             (q_push),
      .q_cmd              (push_cmd),
      .q_first            (push_first),
      .q_last             (push_last)
   );

   urpc_fifo #(
      .DEPTH (QUEUE_DEPTH),
      .WIDTH (ENTRY_W)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (q_push),
      .wr_data  ({push_cmd, push_first, push_last}),
      .is_full  (q_full),
      .rd_en    (q_pop),
      .rd_data  (q_rd_data),
      .is_empty (q_empty)
   );

   assign pop_cmd   = cmd_type'(q_rd_data[ENTRY_W-1 -: CMD_W]);
   assign pop_first = q_rd_data[2*IDX_W-1 -: IDX_W];
   assign pop_last  = q_rd_data[IDX_W-1:0];

   urpc_back #(
      .TABLE_PAGES (TABLE_PAGES),
      .IDX_W       (IDX_W)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_empty     (q_empty),
      .q_pop       (q_pop),
      .q_cmd       (pop_cmd),
      .q_first     (pop_first),
      .q_last      (pop_last),
      .clearing    (clearing),
      .empty       (empty),
      .pop         (pop),
      .rsp_allowed (rsp_allowed)
   );

endmodule

FILE: rtl/urpc_fifo.sv
// small command queue between the classifier and the page walker
module urpc_fifo #(
   parameter int DEPTH = urpc_pkg::DEF_QUEUE_DEPTH,
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_data,
   output logic             is_full,
   input  logic             rd_en,
   output logic [WIDTH-1:0] rd_data,
   output logic             is_empty
);
   import urpc_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_wr, do_rd;

   assign is_full  = (count_ff == CNT_W'(DEPTH));
   assign is_empty = (count_ff == '0);
   assign do_wr    = wr_en & ~is_full;
   assign do_rd    = rd_en & ~is_empty;
   assign rd_data  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

FILE: rtl/urpc_front.sv
// window registers and transaction classifier
module urpc_front #(
   parameter int PAGE_BITS   = urpc_pkg::DEF_PAGE_BITS,
   parameter int TABLE_PAGES = urpc_pkg::DEF_TABLE_PAGES,
   parameter int IDX_W       = $clog2(urpc_pkg::DEF_TABLE_PAGES)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [urpc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [urpc_pkg::ADDR_W-1:0]         csr_data,
   input  logic                                push,
   output logic                                full,
   input  logic [1:0]                          req_mode,
   input  logic [urpc_pkg::ADDR_W-1:0]         req_address,
   input  logic [urpc_pkg::ADDR_W-1:0]         req_length,
   input  logic                                req_entry_mapped,
   input  logic                                req_entry_present,
   input  logic                                req_entry_user,
   input  logic                                req_entry_writable,
   input  logic                                q_full,
   input  logic                                clearing,
   output logic                                q_push,
   output urpc_pkg::cmd_type                   q_cmd,
   output logic [IDX_W-1:0]                    q_first,
   output logic [IDX_W-1:0]                    q_last
);
   import urpc_pkg::*;

   logic [ADDR_W-1:0] win_start_ff, win_start_in;
   logic [ADDR_W-1:0] win_end_ff, win_end_in;
   logic [ADDR_W-1:0] last_addr, first_page, end_page;
   logic              accept, keep;

   assign csr_ready = 1'b1;
   assign full      = q_full | clearing;
   assign accept    = push & ~full;
   assign q_push    = accept & keep;

   assign last_addr  = req_address + req_length - 32'd1;
   assign first_page = req_address >> PAGE_BITS;
   assign end_page   = last_addr >> PAGE_BITS;
   assign q_first    = first_page[IDX_W-1:0];
   assign q_last     = end_page[IDX_W-1:0];

   always_comb begin
      win_start_in = win_start_ff;
      win_end_in   = win_end_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_WIN_START: win_start_in = csr_data;
            CSR_WIN_END:   win_end_in   = csr_data;
            default:       ;
         endcase
      end
   end

   always_comb begin
      keep             = 1'b0;
      q_cmd.kind       = KIND_RESULT;
      q_cmd.need_write = (req_mode == MODE_WRITE);
      q_cmd.result     = 1'b0;
      q_cmd.flags      = {req_entry_writable, req_entry_user, req_entry_present,
                          req_entry_mapped};
      case (req_mode)
         MODE_READ, MODE_WRITE: begin
            keep = 1'b1;
            if (req_length == '0) begin
               q_cmd.result = (req_address >= win_start_ff) && (req_address < win_end_ff);
            end else if ((last_addr < req_address) || (req_address < win_start_ff) ||
                         (last_addr >= win_end_ff) ||
                         (end_page >= ADDR_W'(TABLE_PAGES))) begin
               q_cmd.result = 1'b0;
            end else begin
               q_cmd.kind = KIND_WALK;
            end
         end
         MODE_ENTRY: begin
            q_cmd.kind = KIND_ENTRY;
            keep       = (first_page < ADDR_W'(TABLE_PAGES));
         end
         default: keep = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_start_ff <= WIN_START_RESET;
         win_end_ff   <= WIN_END_RESET;
      end else begin
         win_start_ff <= win_start_in;
         win_end_ff   <= win_end_in;
      end
   end

endmodule

FILE: rtl/urpc_back.sv
// page flag store, page walker and result register
module urpc_back #(
   parameter int TABLE_PAGES = urpc_pkg::DEF_TABLE_PAGES,
   parameter int IDX_W       = $clog2(urpc_pkg::DEF_TABLE_PAGES)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_empty,
   output logic                q_pop,
   input  urpc_pkg::cmd_type   q_cmd,
   input  logic [IDX_W-1:0]    q_first,
   input  logic [IDX_W-1:0]    q_last,
   output logic                clearing,
   output logic                empty,
   input  logic                pop,
   output logic                rsp_allowed
);
   import urpc_pkg::*;

   `include "user_range_permission_check_defines.svh"

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_WALK  = 4'b0100,
      ST_HOLD  = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  walk_page_ff, walk_page_in;
   logic [IDX_W-1:0]  walk_last_ff, walk_last_in;
   logic              walk_write_ff, walk_write_in;
   logic              issuing_ff, issuing_in;
   logic              rd_pend_ff, rd_pend_in;
   logic              rd_last_ff, rd_last_in;
   logic              res_ff, res_in;
   logic              out_valid_ff, out_valid_in;
   logic              out_allowed_ff, out_allowed_in;
   logic [FLAG_W-1:0] rd_data_ff;
   logic [FLAG_W-1:0] flag_mem [TABLE_PAGES];

   logic              mem_we;
   logic [IDX_W-1:0]  mem_waddr;
   logic [FLAG_W-1:0] mem_wdata;
   logic              out_free, load, load_val, finish, fin_val, at_last;

   assign clearing    = (state_ff == ST_CLEAR);
   assign empty       = ~out_valid_ff;
   assign rsp_allowed = out_allowed_ff;
   assign out_free    = ~out_valid_ff | pop;
   assign at_last     = (walk_page_ff == walk_last_ff);

   always_comb begin
      state_in      = state_ff;
      walk_page_in  = walk_page_ff;
      walk_last_in  = walk_last_ff;
      walk_write_in = walk_write_ff;
      issuing_in    = issuing_ff;
      rd_pend_in    = 1'b0;
      rd_last_in    = rd_last_ff;
      res_in        = res_ff;
      q_pop         = 1'b0;
      mem_we        = 1'b0;
      mem_waddr     = q_first;
      mem_wdata     = q_cmd.flags;
      load          = 1'b0;
      load_val      = 1'b0;
      finish        = 1'b0;
      fin_val       = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = walk_page_ff;
            mem_wdata = '0;
            if (walk_page_ff == IDX_W'(TABLE_PAGES - 1)) begin
               walk_page_in = '0;
               state_in     = ST_IDLE;
            end else begin
               walk_page_in = walk_page_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (!q_empty) begin
               case (q_cmd.kind)
                  KIND_ENTRY: begin
                     q_pop  = 1'b1;
                     mem_we = 1'b1;
                  end
                  KIND_RESULT: begin
                     if (out_free) begin
                        q_pop    = 1'b1;
                        load     = 1'b1;
                        load_val = q_cmd.result;
                     end
                  end
                  KIND_WALK: begin
                     q_pop         = 1'b1;
                     walk_page_in  = q_first;
                     walk_last_in  = q_last;
                     walk_write_in = q_cmd.need_write;
                     issuing_in    = 1'b1;
                     state_in      = ST_WALK;
                  end
                  default: q_pop = 1'b1;
               endcase
            end
         end
         ST_WALK: begin
            if (rd_pend_ff) begin
               if (!page_ok(rd_data_ff, walk_write_ff)) begin
                  finish = 1'b1;
               end else if (rd_last_ff) begin
                  finish  = 1'b1;
                  fin_val = 1'b1;
               end
            end
            if (finish) begin
               issuing_in = 1'b0;
               if (out_free) begin
                  load     = 1'b1;
                  load_val = fin_val;
                  state_in = ST_IDLE;
               end else begin
                  res_in   = fin_val;
                  state_in = ST_HOLD;
               end
            end else if (issuing_ff) begin
               rd_pend_in = 1'b1;
               rd_last_in = at_last;
               issuing_in = ~at_last;
               if (!at_last) begin
                  walk_page_in = walk_page_ff + 1'b1;
               end
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               load     = 1'b1;
               load_val = res_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      out_valid_in   = (out_valid_ff & ~pop) | load;
      out_allowed_in = load ? load_val : out_allowed_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         walk_page_ff  <= '0;
         walk_last_ff  <= '0;
         walk_write_ff <= 1'b0;
         issuing_ff    <= 1'b0;
         rd_pend_ff    <= 1'b0;
         rd_last_ff    <= 1'b0;
         res_ff        <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         walk_page_ff  <= walk_page_in;
         walk_last_ff  <= walk_last_in;
         walk_write_ff <= walk_write_in;
         issuing_ff    <= issuing_in;
         rd_pend_ff    <= rd_pend_in;
         rd_last_ff    <= rd_last_in;
         res_ff        <= res_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_allowed_ff <= out_allowed_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         flag_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= flag_mem[walk_page_ff];
   end

   `URPC_ASSERT_IMPL(a_pop_nonempty, clock, reset, q_pop, !q_empty, "pop from empty queue")
   `URPC_ASSERT_IMPL(a_pend_in_walk, clock, reset, rd_pend_ff, state_ff == ST_WALK,
                     "page read pending outside walk")
   `URPC_ASSERT_IMPL(a_walk_bound, clock, reset, (state_ff == ST_WALK) && issuing_ff,
                     walk_page_ff <= walk_last_ff, "walk cursor past last page")
   `URPC_ASSERT_NEXT(a_result_held, clock, reset, out_valid_ff && !pop,
                     out_valid_ff && $stable(out_allowed_ff), "waiting result changed")

endmodule
